### src/text_stats_and_case_filter_unit_assert.svh
// Assertion macros
`ifndef TEXT_STATS_AND_CASE_FILTER_UNIT_ASSERT_SVH
`define TEXT_STATS_AND_CASE_FILTER_UNIT_ASSERT_SVH

`define TSCF_ASSERT_IMPLY(name, clk, rst_n, a, b) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("tscf assertion failed");

`define TSCF_ASSERT_NEXT(name, clk, rst_n, a, b) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("tscf assertion failed");

`endif

### src/tscf_pkg.sv
package tscf_pkg;

  localparam int CNT_BITS   = 32;
  localparam int MAX_REMOVE = 8;
  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  localparam logic [2:0] MODE_UPPER  = 3'd0;
  localparam logic [2:0] MODE_LOWER  = 3'd1;
  localparam logic [2:0] MODE_TITLE  = 3'd2;
  localparam logic [2:0] MODE_REMOVE = 3'd3;
  localparam logic [2:0] MODE_WRAP   = 3'd4;

  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_SYMBOLS = 2'd1;
  localparam logic [1:0] REG_COUNT   = 2'd2;
  localparam logic [1:0] REG_WIDTH   = 2'd3;

  typedef logic [CNT_BITS-1:0] cnt_t;

  // one queue entry: a transformed byte with its statistics snapshot
  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  byte_val;
    logic        wrap_nl;
    logic        empty;
    logic [31:0] chars;
    logic [31:0] lines;
    logic [31:0] words;
    logic [31:0] longest;
  } entry_t;

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == '1) ? v : cnt_t'(v + 1'b1);
  endfunction

  function automatic logic [31:0] show32(cnt_t v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  function automatic cnt_t cnt_max(cnt_t a, cnt_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

### src/text_stats_and_case_filter_unit.sv
// Text statistics and case filter. Takes one byte per cycle (or an end
// word) while the queue is not full and returns one result per byte, two
// when wrap mode inserts a newline. The front stage classifies the byte,
// updates the saturating counters and applies the transform in the
// accepting cycle; a four-entry queue holds finished entries until the
// result side takes them, so each result is registered in the queue before
// it appears. The end word returns the final statistics and resets the
// counters (the line count to one); configuration is kept.
`include "text_stats_and_case_filter_unit_assert.svh"

module text_stats_and_case_filter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  output logic        empty,
  input  logic        pop,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [31:0] out_char_total,
  output logic [31:0] out_line_total,
  output logic [31:0] out_word_total,
  output logic [31:0] out_longest_line_len,
  output logic        out_empty_input,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  tscf_pkg::entry_t entry, head;
  logic             accept, q_full, q_empty, q_pop;

  assign accept = push && !q_full;
  assign full   = q_full;
  assign empty  = q_empty;

  tscf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cfg_ready      (cfg_ready),
    .entry          (entry)
  );

  tscf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (accept),
    .wr_entry (entry),
    .rd_en    (q_pop),
    .head     (head),
    .q_full   (q_full),
    .q_empty  (q_empty)
  );

  tscf_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .head                 (head),
    .q_empty              (q_empty),
    .pop                  (pop),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_byte             (out_byte),
    .out_last             (out_last),
    .out_char_total       (out_char_total),
    .out_line_total       (out_line_total),
    .out_word_total       (out_word_total),
    .out_longest_line_len (out_longest_line_len),
    .out_empty_input      (out_empty_input)
  );

  `TSCF_ASSERT_NEXT(a_push_fills, clk, rst_n, accept, !empty)
  `TSCF_ASSERT_IMPLY(a_drop_zero, clk, rst_n, !empty && !out_valid, out_byte == 8'd0)
  `TSCF_ASSERT_IMPLY(a_nl_first, clk, rst_n, !empty && !out_last,
                     out_valid && out_byte == tscf_pkg::NEWLINE_BYTE && !out_empty_input)
  `TSCF_ASSERT_IMPLY(a_empty_flag, clk, rst_n, !empty && out_empty_input,
                     out_last && !out_valid && out_char_total == 32'd0)

endmodule

### src/tscf_front.sv
module tscf_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [7:0]             in_text_byte,
  input  logic                   in_end_of_text,
  input  logic                   cfg_valid,
  input  logic [1:0]             cfg_index,
  input  logic [63:0]            cfg_data,
  output logic                   cfg_ready,
  output tscf_pkg::entry_t       entry
);

  logic [2:0]  mode_r;
  logic [63:0] syms_r;
  logic [3:0]  rcnt_r;
  logic [7:0]  width_r;

  tscf_pkg::cnt_t chars_r, chars_nxt;
  tscf_pkg::cnt_t lines_r, lines_nxt;
  tscf_pkg::cnt_t words_r, words_nxt;
  tscf_pkg::cnt_t len_r, len_nxt;
  tscf_pkg::cnt_t longest_r, longest_nxt;
  logic           inword_r, inword_nxt;
  logic           letter_r, letter_nxt;
  logic [7:0]     col_r, col_nxt;

  logic           is_nl, is_sp, is_up, is_lo, start_letter, removed;
  logic [7:0]     up_c, lo_c, wrap_w;
  logic [3:0]     rcnt_eff;
  tscf_pkg::cnt_t d_chars, d_lines, d_words, d_len, d_longest;
  tscf_pkg::cnt_t e_words, e_longest;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= tscf_pkg::MODE_UPPER;
      syms_r  <= '0;
      rcnt_r  <= '0;
      width_r <= 8'd80;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tscf_pkg::REG_MODE:    mode_r  <= cfg_data[2:0];
        tscf_pkg::REG_SYMBOLS: syms_r  <= cfg_data;
        tscf_pkg::REG_COUNT:   rcnt_r  <= cfg_data[3:0];
        tscf_pkg::REG_WIDTH:   width_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign is_nl = (in_text_byte == tscf_pkg::NEWLINE_BYTE);
  assign is_sp = (in_text_byte == 8'd32) || (in_text_byte >= 8'd9 && in_text_byte <= 8'd13);
  assign is_up = (in_text_byte >= 8'd65) && (in_text_byte <= 8'd90);
  assign is_lo = (in_text_byte >= 8'd97) && (in_text_byte <= 8'd122);
  assign up_c  = is_lo ? 8'(in_text_byte - 8'd32) : in_text_byte;
  assign lo_c  = is_up ? 8'(in_text_byte + 8'd32) : in_text_byte;
  assign start_letter = !is_sp && !letter_r && (is_up || is_lo);
  assign rcnt_eff = (rcnt_r > 4'(tscf_pkg::MAX_REMOVE)) ? 4'(tscf_pkg::MAX_REMOVE) : rcnt_r;
  assign wrap_w   = (width_r == 8'd0) ? 8'd1 : width_r;

  always_comb begin
    removed = 1'b0;
    for (int i = 0; i < tscf_pkg::MAX_REMOVE; i++) begin
      if (4'(i) < rcnt_eff && syms_r[8*i +: 8] == in_text_byte) removed = 1'b1;
    end
  end

  // statistics after a data byte
  assign d_chars   = tscf_pkg::sat_inc(chars_r);
  assign d_lines   = is_nl ? tscf_pkg::sat_inc(lines_r) : lines_r;
  assign d_longest = is_nl ? tscf_pkg::cnt_max(len_r, longest_r) : longest_r;
  assign d_len     = is_nl ? '0 : tscf_pkg::sat_inc(len_r);
  assign d_words   = (is_sp && inword_r) ? tscf_pkg::sat_inc(words_r) : words_r;

  // statistics closed by the end item
  assign e_longest = tscf_pkg::cnt_max(len_r, longest_r);
  assign e_words   = inword_r ? tscf_pkg::sat_inc(words_r) : words_r;

  always_comb begin
    chars_nxt   = chars_r;
    lines_nxt   = lines_r;
    words_nxt   = words_r;
    len_nxt     = len_r;
    longest_nxt = longest_r;
    inword_nxt  = inword_r;
    letter_nxt  = letter_r;
    col_nxt     = col_r;
    entry       = '0;
    if (in_end_of_text) begin
      entry.empty   = (chars_r == '0);
      entry.chars   = tscf_pkg::show32(chars_r);
      entry.lines   = tscf_pkg::show32(lines_r);
      entry.words   = tscf_pkg::show32(e_words);
      entry.longest = tscf_pkg::show32(e_longest);
      if (accept) begin
        chars_nxt   = '0;
        lines_nxt   = tscf_pkg::cnt_t'(1);
        words_nxt   = '0;
        len_nxt     = '0;
        longest_nxt = '0;
        inword_nxt  = 1'b0;
        letter_nxt  = 1'b0;
        col_nxt     = '0;
      end
    end else begin
      entry.byte_valid = 1'b1;
      entry.byte_val   = in_text_byte;
      entry.chars      = tscf_pkg::show32(d_chars);
      entry.lines      = tscf_pkg::show32(d_lines);
      entry.words      = tscf_pkg::show32(d_words);
      entry.longest    = tscf_pkg::show32(d_longest);
      case (mode_r)
        tscf_pkg::MODE_UPPER: entry.byte_val = up_c;
        tscf_pkg::MODE_LOWER: entry.byte_val = lo_c;
        tscf_pkg::MODE_TITLE: entry.byte_val = start_letter ? up_c : lo_c;
        tscf_pkg::MODE_REMOVE: begin
          if (removed) begin
            entry.byte_valid = 1'b0;
            entry.byte_val   = '0;
          end
        end
        tscf_pkg::MODE_WRAP: begin
          if (is_nl) begin
            col_nxt = '0;
          end else if (col_r >= wrap_w) begin
            entry.wrap_nl = 1'b1;
            col_nxt       = 8'd1;
          end else begin
            col_nxt = 8'(col_r + 8'd1);
          end
        end
        default: ;
      endcase
      if (!accept) col_nxt = col_r;
      if (accept) begin
        chars_nxt   = d_chars;
        lines_nxt   = d_lines;
        words_nxt   = d_words;
        len_nxt     = d_len;
        longest_nxt = d_longest;
        inword_nxt  = !is_sp;
        letter_nxt  = is_sp ? 1'b0 : (letter_r || start_letter);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_r   <= '0;
      lines_r   <= tscf_pkg::cnt_t'(1);
      words_r   <= '0;
      len_r     <= '0;
      longest_r <= '0;
      inword_r  <= 1'b0;
      letter_r  <= 1'b0;
      col_r     <= '0;
    end else begin
      chars_r   <= chars_nxt;
      lines_r   <= lines_nxt;
      words_r   <= words_nxt;
      len_r     <= len_nxt;
      longest_r <= longest_nxt;
      inword_r  <= inword_nxt;
      letter_r  <= letter_nxt;
      col_r     <= col_nxt;
    end
  end

endmodule

### src/tscf_queue.sv
module tscf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  tscf_pkg::entry_t wr_entry,
  input  logic             rd_en,
  output tscf_pkg::entry_t head,
  output logic             q_full,
  output logic             q_empty
);

  tscf_pkg::entry_t                mem_r [tscf_pkg::QDEPTH];
  logic [tscf_pkg::QPTR_BITS-1:0]  wr_ptr_r, rd_ptr_r;
  logic [tscf_pkg::QPTR_BITS:0]    count_r, count_nxt;
  logic                            do_wr, do_rd;

  assign q_full  = (count_r == (tscf_pkg::QPTR_BITS+1)'(tscf_pkg::QDEPTH));
  assign q_empty = (count_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) count_nxt = count_r + 1'b1;
    if (do_rd && !do_wr) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

### src/tscf_back.sv
module tscf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  tscf_pkg::entry_t head,
  input  logic             q_empty,
  input  logic             pop,
  output logic             q_pop,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic [31:0]      out_char_total,
  output logic [31:0]      out_line_total,
  output logic [31:0]      out_word_total,
  output logic [31:0]      out_longest_line_len,
  output logic             out_empty_input
);

  logic phase_r, phase_nxt;
  logic nl_word, taken;

  // an entry with a wrap newline goes out as two words, newline first
  assign nl_word = head.wrap_nl && !phase_r;
  assign taken   = pop && !q_empty;
  assign q_pop   = taken && !nl_word;

  assign out_valid            = head.byte_valid;
  assign out_byte             = nl_word ? tscf_pkg::NEWLINE_BYTE : head.byte_val;
  assign out_last             = !nl_word;
  assign out_char_total       = head.chars;
  assign out_line_total       = head.lines;
  assign out_word_total       = head.words;
  assign out_longest_line_len = head.longest;
  assign out_empty_input      = head.empty;

  always_comb begin
    phase_nxt = phase_r;
    if (taken) phase_nxt = nl_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

### verif/text_stats_and_case_filter_unit_test.sv
module text_stats_and_case_filter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        has_byte;
    logic [7:0]  text;
    logic        last;
    logic [31:0] chars;
    logic [31:0] lines;
    logic [31:0] words;
    logic [31:0] longest;
    logic        empty_flag;
  } snapshot_t;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_text_byte;
  logic        in_end_of_text;
  logic        empty;
  logic        pop;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [31:0] out_char_total;
  logic [31:0] out_line_total;
  logic [31:0] out_word_total;
  logic [31:0] out_longest_line_len;
  logic        out_empty_input;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  // predicted block state and register copies
  logic [31:0] n_chars, n_lines, n_words, cur_line_len, max_line_len;
  logic        in_word, saw_letter;
  logic [7:0]  wrap_col;
  logic [2:0]  mode_q;
  logic [63:0] symbols_q;
  logic [3:0]  sym_count_q;
  logic [7:0]  width_q;

  snapshot_t snapshots_due[$];
  snapshot_t head;
  int        mismatch_count = 0;
  int        items_sent = 0;
  int        burst_left = 0;
  int        hold_off_left = 0;

  text_stats_and_case_filter_unit uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .push                 (push),
    .full                 (full),
    .in_text_byte         (in_text_byte),
    .in_end_of_text       (in_end_of_text),
    .empty                (empty),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_byte             (out_byte),
    .out_last             (out_last),
    .out_char_total       (out_char_total),
    .out_line_total       (out_line_total),
    .out_word_total       (out_word_total),
    .out_longest_line_len (out_longest_line_len),
    .out_empty_input      (out_empty_input),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_capital(input logic [7:0] c);
    return c >= 8'h41 && c <= 8'h5A;
  endfunction

  function automatic logic is_small(input logic [7:0] c);
    return c >= 8'h61 && c <= 8'h7A;
  endfunction

  function automatic logic [7:0] raise(input logic [7:0] c);
    return is_small(c) ? c - 8'h20 : c;
  endfunction

  function automatic logic [7:0] lower(input logic [7:0] c);
    return is_capital(c) ? c + 8'h20 : c;
  endfunction

  function automatic void clear_stream();
    n_chars = '0;
    n_lines = 32'd1;
    n_words = '0;
    cur_line_len = '0;
    max_line_len = '0;
    in_word = 1'b0;
    saw_letter = 1'b0;
    wrap_col = '0;
  endfunction

  function automatic void owe_result(input logic v, input logic [7:0] b, input logic lst,
                                     input logic none_read);
    snapshot_t s;
    s.has_byte = v;
    s.text = v ? b : 8'h00;
    s.last = lst;
    s.chars = n_chars;
    s.lines = n_lines;
    s.words = n_words;
    s.longest = max_line_len;
    s.empty_flag = none_read;
    snapshots_due.push_back(s);
  endfunction

  task automatic filter_and_count(input logic [7:0] c, input logic eot);
    logic       first_letter;
    logic       none_read;
    logic       hit;
    logic [7:0] lim;
    int         n;
    first_letter = 1'b0;
    if (eot) begin
      none_read = (n_chars == 0);
      if (cur_line_len > max_line_len) max_line_len = cur_line_len;
      if (in_word) n_words = bump(n_words);
      owe_result(1'b0, 8'h00, 1'b1, none_read);
      clear_stream();
      return;
    end
    n_chars = bump(n_chars);
    if (c == tscf_pkg::NEWLINE_BYTE) begin
      n_lines = bump(n_lines);
      if (cur_line_len > max_line_len) max_line_len = cur_line_len;
      cur_line_len = '0;
    end else begin
      cur_line_len = bump(cur_line_len);
    end
    if (!is_blank(c)) begin
      in_word = 1'b1;
      if (!saw_letter && (is_capital(c) || is_small(c))) begin
        first_letter = 1'b1;
        saw_letter = 1'b1;
      end
    end else begin
      if (in_word) n_words = bump(n_words);
      in_word = 1'b0;
      saw_letter = 1'b0;
    end
    case (mode_q)
      tscf_pkg::MODE_UPPER: owe_result(1'b1, raise(c), 1'b1, 1'b0);
      tscf_pkg::MODE_LOWER: owe_result(1'b1, lower(c), 1'b1, 1'b0);
      tscf_pkg::MODE_TITLE:
        owe_result(1'b1, first_letter ? raise(c) : lower(c), 1'b1, 1'b0);
      tscf_pkg::MODE_REMOVE: begin
        hit = 1'b0;
        n = (sym_count_q > tscf_pkg::MAX_REMOVE) ? tscf_pkg::MAX_REMOVE : sym_count_q;
        for (int i = 0; i < n; i++)
          if (symbols_q[8*i +: 8] == c) hit = 1'b1;
        owe_result(!hit, c, 1'b1, 1'b0);
      end
      tscf_pkg::MODE_WRAP: begin
        lim = (width_q == 0) ? 8'd1 : width_q;
        if (c == tscf_pkg::NEWLINE_BYTE) begin
          wrap_col = '0;
          owe_result(1'b1, c, 1'b1, 1'b0);
        end else if (wrap_col >= lim) begin
          wrap_col = 8'd1;
          owe_result(1'b1, tscf_pkg::NEWLINE_BYTE, 1'b0, 1'b0);
          owe_result(1'b1, c, 1'b1, 1'b0);
        end else begin
          wrap_col = wrap_col + 8'd1;
          owe_result(1'b1, c, 1'b1, 1'b0);
        end
      end
      default: owe_result(1'b1, c, 1'b1, 1'b0);
    endcase
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("%0t: mismatch on %s: got %0h want %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (snapshots_due.size() == 0) begin
        flag_mismatch("word with none due", out_byte, 0);
      end else begin
        head = snapshots_due.pop_front();
        if (out_valid !== head.has_byte) flag_mismatch("out_valid", out_valid, head.has_byte);
        if (out_byte !== head.text) flag_mismatch("out_byte", out_byte, head.text);
        if (out_last !== head.last) flag_mismatch("out_last", out_last, head.last);
        if (out_char_total !== head.chars)
          flag_mismatch("out_char_total", out_char_total, head.chars);
        if (out_line_total !== head.lines)
          flag_mismatch("out_line_total", out_line_total, head.lines);
        if (out_word_total !== head.words)
          flag_mismatch("out_word_total", out_word_total, head.words);
        if (out_longest_line_len !== head.longest)
          flag_mismatch("out_longest_line_len", out_longest_line_len, head.longest);
        if (out_empty_input !== head.empty_flag)
          flag_mismatch("out_empty_input", out_empty_input, head.empty_flag);
      end
    end
  end

  // result side: long hold-offs on request, otherwise a rotating stall pattern
  initial begin : result_taker
    logic [15:0] pat;
    int          pat_age;
    pop = 1'b0;
    pat = '1;
    pat_age = 0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        hold_off_left--;
        pop <= 1'b0;
      end else begin
        if (pat_age == 0) begin
          pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
          pat_age = $urandom_range(16, 80);
        end
        pat_age--;
        pop <= pat[0];
        pat = {pat[0], pat[15:1]};
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eot);
    @(negedge clk);
    push <= 1'b1;
    in_text_byte <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (full);
    filter_and_count(b, eot);
    items_sent++;
  endtask

  task automatic send_paced(input logic [7:0] b, input logic eot);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        push <= 1'b0;
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    send_item(b, eot);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (snapshots_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tscf_pkg::REG_MODE:    mode_q = val[2:0];
      tscf_pkg::REG_SYMBOLS: symbols_q = val;
      tscf_pkg::REG_COUNT:   sym_count_q = val[3:0];
      tscf_pkg::REG_WIDTH:   width_q = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // unused upper data bits carry junk
  task automatic set_registers(input logic [2:0] m, input logic [63:0] syms,
                               input logic [3:0] cnt, input logic [7:0] wid);
    logic [63:0] junk;
    settle();
    junk = {$urandom, $urandom};
    write_reg(tscf_pkg::REG_MODE, {junk[63:3], m});
    write_reg(tscf_pkg::REG_SYMBOLS, syms);
    write_reg(tscf_pkg::REG_COUNT, {junk[63:4], cnt});
    write_reg(tscf_pkg::REG_WIDTH, {junk[63:8], wid});
  endtask

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 28) return 8'($urandom_range(8'h61, 8'h7A));
    if (r < 55) return 8'($urandom_range(8'h41, 8'h5A));
    if (r < 70) return 8'h20;
    if (r < 77) return tscf_pkg::NEWLINE_BYTE;
    if (r < 82) return 8'($urandom_range(8'h09, 8'h0D));
    if (r < 88) return 8'($urandom_range(8'h21, 8'h40));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_empty_stream();
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_upper_case();
    send_item(8'h61, 1'b0);
    send_item(8'h7B, 1'b0);
    send_item(8'h60, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h5A, 1'b1);
  endtask

  task automatic test_lower_case();
    set_registers(tscf_pkg::MODE_LOWER, '0, 4'd0, 8'd80);
    send_text("Z@[ \n");
  endtask

  task automatic test_title_case();
    set_registers(tscf_pkg::MODE_TITLE, '0, 4'd0, 8'd80);
    send_text("hI 3x\tyZ\n");
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_symbol_removal();
    // count above the symbol limit acts as eight symbols
    set_registers(tscf_pkg::MODE_REMOVE, 64'h2167_6665_6463_6261, 4'hF, 8'd80);
    send_text("a!q");
    set_registers(tscf_pkg::MODE_REMOVE, 64'h2167_6665_6463_6261, 4'd0, 8'd80);
    send_text("a");
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_wrap();
    set_registers(tscf_pkg::MODE_WRAP, '0, 4'd0, 8'd0);
    send_text("ab\nc");
    set_registers(tscf_pkg::MODE_WRAP, '0, 4'd0, 8'd6);
    send_text("\nabcd");
    // column now lies beyond the narrower width
    set_registers(tscf_pkg::MODE_WRAP, '0, 4'd0, 8'd2);
    send_text("e");
    set_registers(tscf_pkg::MODE_WRAP, '0, 4'd0, 8'd255);
    send_text("f");
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_spare_modes();
    logic [2:0] m;
    m = tscf_pkg::MODE_WRAP;
    repeat (3) begin
      m++;
      set_registers(m, '0, 4'd0, 8'd80);
      send_text("a");
    end
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_queue_backpressure();
    set_registers(tscf_pkg::MODE_WRAP, '0, 4'd0, 8'd1);
    hold_off_left = 150;
    repeat (30) send_item(pick_text_byte(), 1'b0);
    send_item(8'h00, 1'b1);
    settle();
  endtask

  task automatic test_sender_pause();
    set_registers(tscf_pkg::MODE_TITLE, '0, 4'd0, 8'd80);
    repeat (12) send_paced(pick_text_byte(), 1'b0);
    settle();
    repeat (12) send_paced(pick_text_byte(), 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic pick_random_registers();
    logic [63:0] syms;
    logic [3:0]  cnt;
    logic [7:0]  wid;
    case ($urandom_range(0, 3))
      0: syms = '0;
      1: syms = '1;
      default: for (int i = 0; i < 8; i++) syms[8*i +: 8] = pick_text_byte();
    endcase
    case ($urandom_range(0, 3))
      0: cnt = 4'd0;
      1: cnt = 4'(tscf_pkg::MAX_REMOVE);
      2: cnt = 4'hF;
      default: cnt = 4'($urandom_range(1, 15));
    endcase
    case ($urandom_range(0, 5))
      0: wid = 8'd0;
      1: wid = 8'd1;
      2: wid = 8'd255;
      default: wid = 8'($urandom_range(2, 12));
    endcase
    set_registers(3'($urandom_range(0, 7)), syms, cnt, wid);
  endtask

  task automatic test_random_streams();
    int target;
    int len;
    target = 600;
    while (items_sent < target) begin
      pick_random_registers();
      repeat ($urandom_range(2, 5)) begin
        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
        repeat (len) send_paced(pick_text_byte(), 1'b0);
        if ($urandom_range(0, 3) != 0) send_paced(8'($urandom), 1'b1);
      end
    end
  endtask

  initial begin : main_sequence
    int guard;
    rst_n = 1'b0;
    push = 1'b0;
    in_text_byte = '0;
    in_end_of_text = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = tscf_pkg::REG_MODE;
    cfg_data = '0;
    mode_q = tscf_pkg::MODE_UPPER;
    symbols_q = '0;
    sym_count_q = '0;
    width_q = 8'd80;
    clear_stream();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_stream();
    test_upper_case();
    test_lower_case();
    test_title_case();
    test_symbol_removal();
    test_wrap();
    test_spare_modes();
    test_queue_backpressure();
    test_sender_pause();
    test_random_streams();

    @(negedge clk);
    push <= 1'b0;
    guard = 0;
    while (snapshots_due.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (snapshots_due.size() != 0)
      flag_mismatch("words never delivered", snapshots_due.size(), 0);
    if (mismatch_count == 0) begin
      $display("text_stats_and_case_filter_unit_test: done, clean");
    end else begin
      $display("text_stats_and_case_filter_unit_test: done, errors");
    end
    $finish;
  end

  initial begin : run_limit
    #10_000_000;
    $display("text_stats_and_case_filter_unit_test: done, errors");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/tscf_pkg.sv
src/tscf_front.sv
src/tscf_queue.sv
src/tscf_back.sv
src/text_stats_and_case_filter_unit.sv
verif/text_stats_and_case_filter_unit_test.sv
